// File: sv/rgma_pkg.sv
// Shared types and constants for the range gate magnitude averager.
`default_nettype none
package rgma_pkg;
   localparam int MAX_GATES_DEFAULT = 512;
   localparam logic [9:0] GATES_RESET = 10'd500;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_STRAY = 2'd2;

   typedef struct packed {
      logic load_start;   // latch count, start dividing by gate count
      logic load_sample;  // latch I/Q, start both square roots
      logic size_gate;    // size the next gate from the accumulator
      logic add_mags;     // fold both magnitudes into the sums
      logic start_mean;   // start both mean divisions
      logic close_gate;   // advance gate or close pulse
   } rgma_cmd_type;

   typedef struct packed {
      logic busy;         // a divider or square root unit is running
      logic short_pulse;  // latched count below gate count
      logic pulse_active;
      logic gate_full;    // samples_in_gate reached current_gate_size
   } rgma_stat_type;
endpackage
`default_nettype wire

// File: sv/rgma_isqrt.sv
// Bit-serial integer square root, two result bits per cycle.
`default_nettype none
module rgma_isqrt
   import rgma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] radicand,
   output logic             busy,
   output logic [23:0]      root
);
   logic [47:0] rem_ff, rem_in;
   logic [23:0] root_ff, root_in;
   logic [47:0] rad_ff, rad_in;
   logic [3:0]  step_ff, step_in;
   logic        busy_ff, busy_in;

   // Two radix-2 digit steps per cycle, for 24 root bits in all.
   always_comb begin
      logic [49:0] trial;
      logic [47:0] r;
      logic [23:0] q;
      logic [47:0] a;
      r = rem_ff; q = root_ff; a = rad_ff;
      trial = '0;
      for (int k = 0; k < 2; k++) begin
         r = {r[45:0], a[47:46]};
         a = {a[45:0], 2'b00};
         trial = {2'b00, r} - {24'd0, q, 2'b01};
         if (!trial[49]) begin
            r = trial[47:0];
            q = {q[22:0], 1'b1};
         end else begin
            q = {q[22:0], 1'b0};
         end
      end
      rem_in = rem_ff; root_in = root_ff; rad_in = rad_ff;
      step_in = step_ff; busy_in = busy_ff;
      if (start) begin
         rem_in = '0; root_in = '0; rad_in = radicand;
         step_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = r; root_in = q; rad_in = a;
         step_in = step_ff + 4'd1;
         if (step_ff == 4'd11) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

// File: sv/rgma_divider.sv
// Restoring divider, two quotient bits per cycle.
`default_nettype none
module rgma_divider
   import rgma_pkg::*;
#(
   parameter int N_W = 40,
   parameter int D_W = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [N_W-1:0] numer,
   input  wire logic [D_W-1:0] denom,
   output logic                busy,
   output logic [N_W-1:0]      quot,
   output logic [D_W-1:0]      remd
);
   localparam int STEPS = (N_W + 1) / 2;
   localparam int SW = $clog2(STEPS + 1);

   logic [D_W-1:0] rem_ff, rem_in;
   logic [N_W-1:0] q_ff, q_in;
   logic [D_W-1:0] den_ff, den_in;
   logic [SW-1:0]  step_ff, step_in;
   logic           busy_ff, busy_in;

   always_comb begin
      logic [D_W:0]   r;
      logic [D_W:0]   t;
      logic [N_W-1:0] q;
      r = {1'b0, rem_ff}; q = q_ff; t = '0;
      for (int k = 0; k < 2; k++) begin
         r = {r[D_W-1:0], q[N_W-1]};
         q = {q[N_W-2:0], 1'b0};
         t = r - {1'b0, den_ff};
         if (!t[D_W]) begin
            r = t;
            q[0] = 1'b1;
         end
      end
      rem_in = rem_ff; q_in = q_ff; den_in = den_ff;
      step_in = step_ff; busy_in = busy_ff;
      if (start) begin
         rem_in = '0; q_in = numer; den_in = denom;
         step_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = r[D_W-1:0]; q_in = q;
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;
   assign remd = rem_ff;
endmodule
`default_nettype wire

// File: sv/rgma_datapath.sv
// Gate sizing, magnitude sums and mean division for the averager.
`default_nettype none
module rgma_datapath
   import rgma_pkg::*;
#(
   parameter int MAX_GATES = MAX_GATES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rgma_cmd_type cmd,
   output rgma_stat_type    stat,
   input  wire logic [9:0]  gates_in_use,
   input  wire logic [15:0] sample_count,
   input  wire logic [15:0] v_inphase,
   input  wire logic [15:0] v_quadrature,
   input  wire logic [15:0] h_inphase,
   input  wire logic [15:0] h_quadrature,
   output logic [8:0]       gate_index,
   output logic [23:0]      v_mean,
   output logic [23:0]      h_mean,
   output logic             last_gate
);
   localparam int GW = $clog2(MAX_GATES + 1);

   // Effective gate count, clamped to 1..MAX_GATES.
   logic [12:0] g_eff;
   always_comb begin
      if (gates_in_use == 10'd0) g_eff = 13'd1;
      else if (13'(gates_in_use) > 13'(MAX_GATES)) g_eff = 13'(MAX_GATES);
      else g_eff = 13'(gates_in_use);
   end

   logic        pulse_ff, pulse_in;
   logic        short_ff, short_in;
   logic [15:0] base_ff, base_in;
   logic [8:0]  grem_ff, grem_in;
   logic [9:0]  acc_ff, acc_in;
   logic [8:0]  gate_ff, gate_in;
   logic [15:0] gsize_ff, gsize_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [39:0] vsum_ff, vsum_in, hsum_ff, hsum_in;
   logic        last_ff, last_in;

   // Square roots of (I^2+Q^2) << 16.
   logic signed [15:0] vi, vq, hi, hq;
   logic [32:0] vpow, hpow;
   logic [23:0] vroot, hroot;
   logic        vbusy, hbusy;
   assign vi = v_inphase; assign vq = v_quadrature;
   assign hi = h_inphase; assign hq = h_quadrature;
   assign vpow = 33'($unsigned(32'(vi * vi))) + 33'($unsigned(32'(vq * vq)));
   assign hpow = 33'($unsigned(32'(hi * hi))) + 33'($unsigned(32'(hq * hq)));

   rgma_isqrt u_vsqrt (.clock, .reset, .start(cmd.load_sample),
      .radicand({vpow[31:0], 16'd0}), .busy(vbusy), .root(vroot));
   rgma_isqrt u_hsqrt (.clock, .reset, .start(cmd.load_sample),
      .radicand({hpow[31:0], 16'd0}), .busy(hbusy), .root(hroot));

   // One shared-form divider per channel; the V divider also splits the count.
   logic [39:0] vq_out, hq_out;
   logic [15:0] vr_out, hr_out;
   logic        vdbusy, hdbusy;
   logic [39:0] vnum;
   logic [15:0] vden;
   assign vnum = cmd.load_start ? {24'd0, sample_count} : vsum_ff;
   assign vden = cmd.load_start ? 16'(g_eff) : gsize_ff;

   rgma_divider #(.N_W(40), .D_W(16)) u_vdiv (.clock, .reset,
      .start(cmd.load_start | cmd.start_mean), .numer(vnum), .denom(vden),
      .busy(vdbusy), .quot(vq_out), .remd(vr_out));
   rgma_divider #(.N_W(40), .D_W(16)) u_hdiv (.clock, .reset,
      .start(cmd.start_mean), .numer(hsum_ff), .denom(gsize_ff),
      .busy(hdbusy), .quot(hq_out), .remd(hr_out));

   logic [10:0] acc_sum;
   logic [15:0] gs;
   always_comb begin
      pulse_in = pulse_ff; short_in = short_ff; base_in = base_ff;
      grem_in = grem_ff; acc_in = acc_ff; gate_in = gate_ff;
      gsize_in = gsize_ff; cnt_in = cnt_ff; vsum_in = vsum_ff;
      hsum_in = hsum_ff; last_in = last_ff;
      acc_sum = 11'(acc_ff) + 11'(grem_ff);
      gs = base_ff;
      if (cmd.load_start) begin
         pulse_in = 1'b0;
         short_in = 17'(sample_count) < 17'(g_eff);
         acc_in = '0;
         gate_in = '0;
      end
      if (cmd.size_gate) begin
         // First sizing after a start also takes the quotient and remainder.
         if (!pulse_ff) begin
            base_in = vq_out[15:0];
            grem_in = vr_out[8:0];
            acc_sum = 11'(vr_out[8:0]);
            gs = vq_out[15:0];
         end
         pulse_in = 1'b1;
         acc_in = acc_sum[9:0];
         if ({3'd0, acc_sum[9:0]} >= g_eff) begin
            acc_in = 10'(13'(acc_sum[9:0]) - g_eff);
            gs = gs + 16'd1;
         end
         gsize_in = (gs == 16'd0) ? 16'd1 : gs;
         cnt_in = '0; vsum_in = '0; hsum_in = '0;
      end
      if (cmd.add_mags) begin
         vsum_in = vsum_ff + 40'(vroot);
         hsum_in = hsum_ff + 40'(hroot);
         cnt_in = cnt_ff + 16'd1;
      end
      if (cmd.start_mean)
         last_in = 13'(gate_ff) + 13'd1 >= g_eff;
      if (cmd.close_gate) begin
         if (last_ff) begin
            pulse_in = 1'b0;
            cnt_in = '0; vsum_in = '0; hsum_in = '0;
         end else begin
            gate_in = gate_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= 1'b0;
         short_ff <= 1'b0;
         base_ff  <= '0;
         grem_ff  <= '0;
         acc_ff   <= '0;
         gate_ff  <= '0;
         gsize_ff <= '0;
         cnt_ff   <= '0;
         vsum_ff  <= '0;
         hsum_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         pulse_ff <= pulse_in;
         short_ff <= short_in;
         base_ff  <= base_in;
         grem_ff  <= grem_in;
         acc_ff   <= acc_in;
         gate_ff  <= gate_in;
         gsize_ff <= gsize_in;
         cnt_ff   <= cnt_in;
         vsum_ff  <= vsum_in;
         hsum_ff  <= hsum_in;
         last_ff  <= last_in;
      end
   end

   assign stat.busy = vbusy | hbusy | vdbusy | hdbusy;
   assign stat.short_pulse = short_ff;
   assign stat.pulse_active = pulse_ff;
   assign stat.gate_full = cnt_ff >= gsize_ff;
   assign gate_index = gate_ff;
   assign v_mean = vq_out[23:0];
   assign h_mean = hq_out[23:0];
   assign last_gate = last_ff;

   logic unused;
   assign unused = ^{GW, vpow[32], hpow[32], vq_out[39:24], hq_out[39:24], hr_out, vr_out[15:9]};

   a_gate_size: assert property (@(posedge clock) disable iff (reset)
      pulse_ff |-> gsize_ff != 16'd0) else $error("open pulse with empty gate");
   a_load_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_start && cmd.load_sample)) else $error("start and sample at once");
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      pulse_ff |-> 13'(acc_ff) < g_eff + 13'(MAX_GATES)) else $error("accumulator overflow");
endmodule
`default_nettype wire

// File: sv/rgma_control.sv
// Sequencer for start, sample and gate-close steps.
`default_nettype none
module rgma_control
   import rgma_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_type,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [1:0]        rsp_status,
   output logic              rsp_zero,
   output logic              csr_idle,
   output rgma_cmd_type      cmd,
   input  wire rgma_stat_type stat
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SPLIT = 8'b0000_0010,
      S_ROOT  = 8'b0000_0100,
      S_ADD   = 8'b0000_1000,
      S_MEAN  = 8'b0001_0000,
      S_SEND  = 8'b0010_0000,
      S_ERR   = 8'b0100_0000,
      S_SIZE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       wait_ff, wait_in;   // holds off the busy check until a started unit's busy has risen

   always_comb begin
      state_in = state_ff; status_in = status_ff; wait_in = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            if (!req_type) begin
               cmd.load_start = 1'b1; wait_in = 1'b1; state_in = S_SPLIT;
            end else if (!stat.pulse_active) begin
               status_in = STATUS_STRAY; state_in = S_ERR;
            end else begin
               cmd.load_sample = 1'b1; wait_in = 1'b1; state_in = S_ROOT;
            end
         end
         S_SPLIT: if (!wait_ff && !stat.busy) begin
            if (stat.short_pulse) begin
               status_in = STATUS_SHORT; state_in = S_ERR;
            end else begin
               cmd.size_gate = 1'b1; state_in = S_IDLE;
            end
         end
         S_ROOT: if (!wait_ff && !stat.busy) begin
            cmd.add_mags = 1'b1; state_in = S_ADD;
         end
         S_ADD: if (stat.gate_full) begin
            cmd.start_mean = 1'b1; wait_in = 1'b1; state_in = S_MEAN;
         end else state_in = S_IDLE;
         S_MEAN: if (!wait_ff && !stat.busy) state_in = S_SEND;
         S_SEND: if (!rsp_stall) begin
            cmd.close_gate = 1'b1; state_in = S_SIZE;
         end
         S_SIZE: begin
            if (stat.pulse_active) cmd.size_gate = 1'b1;
            state_in = S_IDLE;
         end
         S_ERR: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= STATUS_OK;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         wait_ff <= wait_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_SEND || state_ff == S_ERR;
   assign rsp_status = state_ff == S_SEND ? STATUS_OK : status_ff;
   assign rsp_zero = state_ff == S_ERR;
   assign csr_idle = state_ff == S_IDLE;

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("overlapping commands");
endmodule
`default_nettype wire

// File: sv/range_gate_magnitude_average.sv
// Range gate magnitude averager, top level.
// Input channel (req_*): valid/stall. A beat with req_type 0 starts a pulse
// with sample_count; req_type 1 carries V and H I/Q samples.
// Result channel (rsp_*): valid/stall, one beat per filled gate or error.
// Configuration (csr_*): valid/ready write of gates_in_use; ready while idle.
// Per beat: a start item runs the 20-step count divider; a sample runs the
// 12-step square roots, and when it fills a gate also the 20-step mean
// dividers and the result beat.
// A sample outside a pulse gives its error beat the cycle after acceptance;
// a short pulse gives its beat after the count divide.
// One item is in flight at a time; req_stall is high until it is finished,
// including while a result beat waits under rsp_stall, whose payload holds.
// Synchronous reset clears the sequencer and pulse state; gates_in_use
// returns to 500.
`default_nettype none
module range_gate_magnitude_average
   import rgma_pkg::*;
#(
   parameter int MAX_GATES = MAX_GATES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [15:0] req_sample_count,
   input  wire logic [15:0] req_v_inphase,
   input  wire logic [15:0] req_v_quadrature,
   input  wire logic [15:0] req_h_inphase,
   input  wire logic [15:0] req_h_quadrature,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [8:0]       rsp_gate_index,
   output logic [23:0]      rsp_v_mean,
   output logic [23:0]      rsp_h_mean,
   output logic             rsp_last_gate,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [9:0]  csr_gates_in_use
);
   logic [9:0] gates_ff, gates_in;
   logic [15:0] cnt_ff, vi_ff, vq_ff, hi_ff, hq_ff;
   rgma_cmd_type cmd;
   rgma_stat_type stat;
   logic zero, idle;
   logic [8:0] gidx;
   logic [23:0] vm, hm;
   logic lg;

   always_comb begin
      gates_in = gates_ff;
      if (csr_valid && csr_ready) gates_in = csr_gates_in_use;
   end

   always_ff @(posedge clock) begin
      if (reset) gates_ff <= GATES_RESET;
      else gates_ff <= gates_in;
      // Hold the accepted beat's payload for the units.
      if (req_valid && !req_stall) begin
         cnt_ff <= req_sample_count;
         vi_ff <= req_v_inphase; vq_ff <= req_v_quadrature;
         hi_ff <= req_h_inphase; hq_ff <= req_h_quadrature;
      end
   end

   // The units start the cycle after acceptance, from the held payload.
   logic load_start_ff, load_sample_ff;
   logic [1:0] st;
   rgma_control u_ctrl (.clock, .reset, .req_valid, .req_stall, .req_type,
      .rsp_valid, .rsp_stall, .rsp_status(st), .rsp_zero(zero),
      .csr_idle(idle), .cmd, .stat(stat));

   always_ff @(posedge clock) begin
      if (reset) begin
         load_start_ff <= 1'b0;
         load_sample_ff <= 1'b0;
      end else begin
         load_start_ff <= cmd.load_start;
         load_sample_ff <= cmd.load_sample;
      end
   end

   // Start and sample loads go in through a register; other commands go in directly.
   rgma_cmd_type cmd_dp;
   always_comb begin
      cmd_dp = cmd;
      cmd_dp.load_start = load_start_ff;
      cmd_dp.load_sample = load_sample_ff;
   end

   rgma_datapath #(.MAX_GATES(MAX_GATES)) u_dp (.clock, .reset, .cmd(cmd_dp),
      .stat, .gates_in_use(gates_ff), .sample_count(cnt_ff),
      .v_inphase(vi_ff), .v_quadrature(vq_ff), .h_inphase(hi_ff),
      .h_quadrature(hq_ff), .gate_index(gidx), .v_mean(vm), .h_mean(hm),
      .last_gate(lg));

   assign csr_ready = idle;
   assign rsp_status = st;
   assign rsp_gate_index = zero ? 9'd0 : gidx;
   assign rsp_v_mean = zero ? 24'd0 : vm;
   assign rsp_h_mean = zero ? 24'd0 : hm;
   assign rsp_last_gate = zero ? 1'b0 : lg;

   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !rsp_valid) else $error("config open while busy");
endmodule
`default_nettype wire
